// ===== hdl/cst_pkg.sv =====
// shared types and constants for the source tokenizer
`default_nettype none
package cst_pkg;

	// scan modes
	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_OP    = 4'd1;
	localparam logic [3:0] M_BSL   = 4'd2;
	localparam logic [3:0] M_DOTS  = 4'd3;
	localparam logic [3:0] M_CR    = 4'd4;
	localparam logic [3:0] M_SPACE = 4'd5;
	localparam logic [3:0] M_IDENT = 4'd6;
	localparam logic [3:0] M_NUM   = 4'd7;
	localparam logic [3:0] M_NUMF  = 4'd8;
	localparam logic [3:0] M_NUMT  = 4'd9;
	localparam logic [3:0] M_QUOTE = 4'd10;
	localparam logic [3:0] M_LINEC = 4'd11;
	localparam logic [3:0] M_BLOCK = 4'd12;
	localparam logic [3:0] M_BSTAR = 4'd13;

	// token kinds
	localparam logic [5:0] K_INVALID = 6'd0;
	localparam logic [5:0] K_EOF     = 6'd1;
	localparam logic [5:0] K_SPACE   = 6'd2;
	localparam logic [5:0] K_NEWLINE = 6'd3;
	localparam logic [5:0] K_COMMENT = 6'd4;
	localparam logic [5:0] K_IDENT   = 6'd5;
	localparam logic [5:0] K_INT     = 6'd6;
	localparam logic [5:0] K_FLOAT   = 6'd7;
	localparam logic [5:0] K_CHAR    = 6'd8;
	localparam logic [5:0] K_STRING  = 6'd9;
	localparam logic [5:0] K_BSL     = 6'd23;
	localparam logic [5:0] K_ELLIP   = 6'd24;
	localparam logic [5:0] K_DOT     = 6'd25;
	localparam logic [5:0] K_NONE    = 6'd63;

	// byte constants
	localparam logic [7:0] C_USCORE = 8'h5F;
	localparam logic [7:0] C_HASH   = 8'h23;
	localparam logic [7:0] C_STAR   = 8'h2A;
	localparam logic [7:0] C_SLASH  = 8'h2F;
	localparam logic [7:0] C_DOT    = 8'h2E;
	localparam logic [7:0] C_GT     = 8'h3E;
	localparam logic [7:0] C_LF     = 8'h0A;
	localparam logic [7:0] C_CR     = 8'h0D;
	localparam logic [7:0] C_BSLASH = 8'h5C;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_SQUOTE = 8'h27;

	// one classified request between front and back
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       is_num;
		logic       is_word;
		logic       is_blank;
		logic [5:0] single;
		logic [5:0] lead;
	} cls_t;

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		case (c)
			8'h28: single_kind = 6'd10;
			8'h29: single_kind = 6'd11;
			8'h5B: single_kind = 6'd12;
			8'h5D: single_kind = 6'd13;
			8'h7B: single_kind = 6'd14;
			8'h7D: single_kind = 6'd15;
			8'h3F: single_kind = 6'd16;
			8'h2C: single_kind = 6'd17;
			8'h3A: single_kind = 6'd18;
			8'h3B: single_kind = 6'd19;
			8'h7E: single_kind = 6'd20;
			8'h5E: single_kind = 6'd21;
			8'h21: single_kind = 6'd22;
			default: single_kind = K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] lead_kind(input logic [7:0] c);
		case (c)
			8'h26: lead_kind = 6'd28;
			8'h7C: lead_kind = 6'd31;
			8'h2B: lead_kind = 6'd34;
			8'h2D: lead_kind = 6'd38;
			C_STAR: lead_kind = 6'd40;
			C_SLASH: lead_kind = 6'd42;
			8'h25: lead_kind = 6'd44;
			8'h3D: lead_kind = 6'd45;
			8'h3C: lead_kind = 6'd49;
			C_GT: lead_kind = 6'd52;
			C_HASH: lead_kind = 6'd53;
			default: lead_kind = K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		pair_kind = K_NONE;
		case (a)
			8'h26: pair_kind = (b == 8'h26) ? 6'd26 : (b == 8'h3D) ? 6'd27 : K_NONE;
			8'h7C: pair_kind = (b == 8'h7C) ? 6'd29 : (b == 8'h3D) ? 6'd30 : K_NONE;
			8'h2B: pair_kind = (b == 8'h2B) ? 6'd32 : (b == 8'h3D) ? 6'd33 : K_NONE;
			8'h2D: pair_kind = (b == 8'h2D) ? 6'd35 : (b == C_GT) ? 6'd36 :
				(b == 8'h3D) ? 6'd37 : K_NONE;
			C_STAR: pair_kind = (b == 8'h3D) ? 6'd39 : K_NONE;
			C_SLASH: pair_kind = (b == 8'h3D) ? 6'd41 : K_NONE;
			8'h25: pair_kind = (b == 8'h3D) ? 6'd43 : K_NONE;
			8'h3D: pair_kind = (b == 8'h3D) ? 6'd46 : K_NONE;
			8'h3C: pair_kind = (b == 8'h3D) ? 6'd47 : (b == 8'h3C) ? 6'd48 : K_NONE;
			C_GT: pair_kind = (b == 8'h3D) ? 6'd50 : (b == C_GT) ? 6'd51 : K_NONE;
			C_HASH: pair_kind = (b == C_HASH) ? 6'd54 : K_NONE;
			default: pair_kind = K_NONE;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== hdl/cst_front.sv =====
// front part: accepts bytes, classifies them and queues them for the back part
`default_nettype none
module cst_front
	import cst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] source_byte,
	input  wire logic       end_of_input,
	input  wire logic       valid,
	output logic            stall,
	output cls_t            q_data,
	output logic            q_valid,
	input  wire logic       q_pop
);
	// two-entry queue
	cls_t   mem_q [2];
	logic   rd_q, wr_q;
	logic [1:0] cnt_q;
	cls_t   cls;
	logic   push;
	logic [7:0] b;

	// classify the incoming request
	always_comb begin
		b = source_byte;
		cls.b = b;
		cls.fin = end_of_input || (b == 8'h00);
		cls.is_num = (b >= 8'h30) && (b <= 8'h39);
		cls.is_word = cls.is_num || ((b >= 8'h61) && (b <= 8'h7A)) ||
			((b >= 8'h41) && (b <= 8'h5A)) || (b == C_USCORE);
		cls.is_blank = (b == 8'h20) || (b == C_LF) || (b == 8'h09) || (b == C_CR) ||
			(b == 8'h0C) || (b == 8'h0B);
		cls.single = single_kind(b);
		cls.lead = lead_kind(b);
	end

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/cst_back.sv =====
// back part: runs the scanner and sends out up to three tokens per request
`default_nettype none
module cst_back
	import cst_pkg::*;
#(
	parameter int LENGTH_BITS = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cls_t                   q_data,
	input  wire logic                   q_valid,
	output logic                        q_pop,
	output logic [5:0]                  token_class,
	output logic [OFFSET_BITS-1:0]      token_start,
	output logic [LENGTH_BITS-1:0]      token_length,
	output logic                        last_result,
	output logic                        valid,
	input  wire logic                   stall
);
	localparam logic [LENGTH_BITS-1:0] LMAX = {LENGTH_BITS{1'b1}};

	typedef struct packed {
		logic [5:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] len;
	} tok_t;

	logic [3:0]             mode_q;
	logic [7:0]             held_q;
	logic                   hc2_q;
	logic [7:0]             quote_q;
	logic                   esc_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [OFFSET_BITS-1:0] pos_q;

	// result buffer, drained one token a cycle while the receiver does not stall
	tok_t       buf_q [3];
	logic [1:0] n_q, idx_q;

	logic [3:0]             mode_d;
	logic [7:0]             held_d, quote_d;
	logic                   hc2_d, esc_d;
	logic [LENGTH_BITS-1:0] len_d, len_g;
	logic [OFFSET_BITS-1:0] start_d;
	tok_t                   t [3];
	logic [1:0]             n;
	logic                   took, closing;
	logic [5:0]             pk;
	tok_t                   ct0, ct1;
	logic [1:0]             cn;
	cls_t                   c;

	assign c = q_data;
	// take the next request once the buffer is empty or its last token leaves now
	assign q_pop = q_valid && ((n_q == 2'd0) || (valid && !stall && last_result));
	assign len_g = (len_q == LMAX) ? len_q : len_q + 1'b1;

	// scanner next state and emitted tokens
	always_comb begin
		mode_d = mode_q; held_d = held_q; hc2_d = hc2_q; quote_d = quote_q;
		esc_d = esc_q; len_d = len_q; start_d = start_q;
		t[0] = '0; t[1] = '0; t[2] = '0; n = 2'd0;
		took = 1'b0; closing = 1'b0;
		pk = pair_kind(held_q, c.b);
		ct0 = '0; ct1 = '0; cn = 2'd0;
		// token closed without consuming the byte
		case (mode_q)
			M_IDLE: cn = 2'd0;
			M_DOTS: begin
				ct0 = '{K_DOT, start_q, LENGTH_BITS'(1)};
				ct1 = '{K_DOT, start_q + 1'b1, LENGTH_BITS'(1)};
				cn = hc2_q ? 2'd2 : 2'd1;
			end
			M_OP: begin ct0 = '{lead_kind(held_q), start_q, len_q}; cn = 2'd1; end
			M_BSL: begin ct0 = '{K_BSL, start_q, len_q}; cn = 2'd1; end
			M_CR: begin ct0 = '{K_NEWLINE, start_q, len_q}; cn = 2'd1; end
			M_SPACE: begin ct0 = '{K_SPACE, start_q, len_q}; cn = 2'd1; end
			M_IDENT: begin ct0 = '{K_IDENT, start_q, len_q}; cn = 2'd1; end
			M_NUM, M_NUMT: begin ct0 = '{K_INT, start_q, len_q}; cn = 2'd1; end
			M_NUMF: begin ct0 = '{K_FLOAT, start_q, len_q}; cn = 2'd1; end
			M_QUOTE: begin ct0 = '{K_INVALID, start_q, len_q}; cn = 2'd1; end
			default: begin ct0 = '{K_COMMENT, start_q, len_q}; cn = 2'd1; end
		endcase

		if (c.fin) begin
			closing = 1'b1;
		end else begin
			// offer byte to the open token
			case (mode_q)
				M_IDLE: took = 1'b0;
				M_OP: begin
					if (held_q == C_SLASH && c.b == C_SLASH) begin
						took = 1'b1; len_d = len_g; mode_d = M_LINEC;
					end else if (held_q == C_SLASH && c.b == C_STAR) begin
						took = 1'b1; len_d = len_g; mode_d = M_BLOCK;
					end else if (pk != K_NONE) begin
						took = 1'b1; t[0] = '{pk, start_q, len_g}; n = 2'd1;
						mode_d = M_IDLE;
					end
				end
				M_BSL, M_CR: begin
					if (c.b == C_LF) begin
						took = 1'b1;
						t[0] = '{(mode_q == M_BSL) ? K_SPACE : K_NEWLINE, start_q, len_g};
						n = 2'd1; mode_d = M_IDLE;
					end
				end
				M_DOTS: begin
					if (c.b == C_DOT) begin
						took = 1'b1;
						if (!hc2_q) begin
							hc2_d = 1'b1; len_d = len_g;
						end else begin
							t[0] = '{K_ELLIP, start_q, LENGTH_BITS'(3)}; n = 2'd1;
							hc2_d = 1'b0; mode_d = M_IDLE;
						end
					end
				end
				M_SPACE: if (c.is_blank) begin took = 1'b1; len_d = len_g; end
				M_IDENT, M_NUMF, M_NUMT:
					if (c.is_word) begin took = 1'b1; len_d = len_g; end
				M_NUM: begin
					if (c.is_num) begin
						took = 1'b1; len_d = len_g;
					end else if (c.b == C_DOT) begin
						took = 1'b1; len_d = len_g; mode_d = M_NUMF;
					end else if (c.is_word) begin
						took = 1'b1; len_d = len_g; mode_d = M_NUMT;
					end
				end
				M_QUOTE: begin
					if (esc_q) begin
						took = 1'b1; esc_d = 1'b0; len_d = len_g;
					end else if (c.b == quote_q) begin
						took = 1'b1;
						t[0] = '{(quote_q == C_DQUOTE) ? K_STRING : K_CHAR, start_q, len_g};
						n = 2'd1; mode_d = M_IDLE;
					end else if (c.b != C_LF) begin
						took = 1'b1; len_d = len_g;
						if (c.b == C_BSLASH) esc_d = 1'b1;
					end
				end
				M_LINEC: if (c.b != C_LF) begin took = 1'b1; len_d = len_g; end
				M_BLOCK: begin
					took = 1'b1; len_d = len_g;
					if (c.b == C_STAR) mode_d = M_BSTAR;
				end
				default: begin
					took = 1'b1; len_d = len_g;
					if (c.b == C_SLASH) begin
						t[0] = '{K_COMMENT, start_q, len_g}; n = 2'd1; mode_d = M_IDLE;
					end else if (c.b != C_STAR) begin
						mode_d = M_BLOCK;
					end
				end
			endcase
			if (!took) closing = 1'b1;
		end

		if (closing) begin
			t[0] = ct0; t[1] = ct1; n = cn;
			mode_d = M_IDLE; esc_d = 1'b0; hc2_d = 1'b0;
			if (c.fin) begin
				t[n] = '{K_EOF, pos_q, '0};
				n = n + 2'd1;
			end else begin
				// start a new token at this byte
				start_d = pos_q; len_d = LENGTH_BITS'(1); esc_d = 1'b0;
				if (c.single != K_NONE) begin
					t[n] = '{c.single, pos_q, LENGTH_BITS'(1)}; n = n + 2'd1;
				end else if (c.lead != K_NONE) begin
					held_d = c.b; mode_d = M_OP;
				end else if (c.b == C_LF) begin
					t[n] = '{K_NEWLINE, pos_q, LENGTH_BITS'(1)}; n = n + 2'd1;
				end else if (c.b == C_CR) begin
					mode_d = M_CR;
				end else if (c.b == C_BSLASH) begin
					mode_d = M_BSL;
				end else if (c.b == C_DOT) begin
					mode_d = M_DOTS;
				end else if (c.is_blank) begin
					mode_d = M_SPACE;
				end else if (c.b == C_SQUOTE || c.b == C_DQUOTE) begin
					quote_d = c.b; mode_d = M_QUOTE;
				end else if (c.is_num) begin
					mode_d = M_NUM;
				end else if (c.is_word) begin
					mode_d = M_IDENT;
				end else begin
					t[n] = '{K_INVALID, pos_q, LENGTH_BITS'(1)}; n = n + 2'd1;
				end
			end
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; held_q <= '0; hc2_q <= 1'b0; quote_q <= '0;
			esc_q <= 1'b0; len_q <= '0; start_q <= '0; pos_q <= '0;
		end else if (q_pop) begin
			mode_q <= mode_d; held_q <= held_d; hc2_q <= hc2_d; quote_q <= quote_d;
			esc_q <= esc_d; len_q <= len_d; start_q <= start_d;
			if (!c.fin) pos_q <= pos_q + 1'b1;
		end
	end

	// token buffer payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			buf_q[0] <= t[0]; buf_q[1] <= t[1]; buf_q[2] <= t[2];
		end
	end

	// token buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0; idx_q <= 2'd0;
		end else if (q_pop) begin
			n_q <= n; idx_q <= 2'd0;
		end else if (valid && !stall) begin
			if (idx_q + 2'd1 == n_q) begin
				n_q <= 2'd0; idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign valid = (n_q != 2'd0);
	assign token_class = buf_q[idx_q].kind;
	assign token_start = buf_q[idx_q].start;
	assign token_length = buf_q[idx_q].len;
	assign last_result = (idx_q + 2'd1 == n_q);
endmodule
`default_nettype wire

// ===== hdl/c_source_tokenizer.sv =====
// A token appears in the cycle after the byte that closes it leaves the queue.
// Throughput: one byte per cycle while the receiver does not stall and each byte
// closes at most one token; a byte closing two or three tokens holds the scanner
// until the buffer's single output sends them; the two-entry queue absorbs this.
// Reset: arst_n clears the queue, the scanner to idle and the byte offset to zero.
`default_nettype none
module c_source_tokenizer
	import cst_pkg::*;
#(
	parameter int LENGTH_BITS = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             source_byte,
	input  wire logic                   end_of_input,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	output logic [5:0]                  token_class,
	output logic [OFFSET_BITS-1:0]      token_start,
	output logic [LENGTH_BITS-1:0]      token_length,
	output logic                        last_result,
	output logic                        out_valid,
	input  wire logic                   out_stall
);
	cls_t q_data;
	logic q_valid, q_pop;

	// byte classification and queue
	cst_front u_front (
		.clk, .arst_n, .source_byte, .end_of_input,
		.valid(in_valid), .stall(in_stall),
		.q_data, .q_valid, .q_pop
	);

	// scanner and token output
	cst_back #(.LENGTH_BITS(LENGTH_BITS), .OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk, .arst_n, .q_data, .q_valid, .q_pop,
		.token_class, .token_start, .token_length, .last_result,
		.valid(out_valid), .stall(out_stall)
	);
endmodule
`default_nettype wire

// ===== verif/tb_c_source_tokenizer.sv =====
// self-checking testbench for the streaming C source tokenizer
`default_nettype none
module tb_c_source_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;
	import cst_pkg::*;

	localparam int LB = 16;
	localparam int OB = 32;
	localparam int N_RANDOM = 330;

	typedef struct packed {
		logic [5:0]    kind;
		logic [OB-1:0] start;
		logic [LB-1:0] len;
		logic          last;
	} token_t;

	typedef struct {
		logic [7:0] b;
		logic       fin;
		int         n_fixed;
		token_t     fixed [3];
	} row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic [7:0]    source_byte = '0;
	logic          end_of_input = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [5:0]    token_class;
	logic [OB-1:0] token_start;
	logic [LB-1:0] token_length;
	logic          last_result;
	logic          out_valid;
	logic          out_stall = 1'b0;

	c_source_tokenizer #(.LENGTH_BITS(LB), .OFFSET_BITS(OB)) DUT (
		.clk(clk), .arst_n(arst_n), .source_byte(source_byte), .end_of_input(end_of_input),
		.in_valid(in_valid), .in_stall(in_stall), .token_class(token_class),
		.token_start(token_start), .token_length(token_length), .last_result(last_result),
		.out_valid(out_valid), .out_stall(out_stall)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [3:0]    mode;
	logic [7:0]    lead_byte;
	logic [1:0]    dots;
	logic [7:0]    quote;
	logic          esc;
	logic [LB-1:0] run_len;
	logic [OB-1:0] run_start;
	logic [OB-1:0] offset;

	token_t pending_tokens [$];
	token_t step_tokens [$];
	int     mismatches = 0;
	bit     sending_done = 0;
	bit     long_hold = 0;

	function automatic bit is_dec_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_wordc(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_dec_digit(c) ||
			c == C_USCORE;
	endfunction

	function automatic bit is_ws(input logic [7:0] c);
		return c == " " || c == C_LF || c == 8'h09 || c == C_CR || c == 8'h0C || c == 8'h0B;
	endfunction

	function automatic logic [5:0] singles(input logic [7:0] c);
		case (c)
			"(": return 6'd10; ")": return 6'd11; "[": return 6'd12; "]": return 6'd13;
			"{": return 6'd14; "}": return 6'd15; "?": return 6'd16; ",": return 6'd17;
			":": return 6'd18; ";": return 6'd19; "~": return 6'd20; "^": return 6'd21;
			"!": return 6'd22;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] leads(input logic [7:0] c);
		case (c)
			"&": return 6'd28; "|": return 6'd31; "+": return 6'd34; "-": return 6'd38;
			"*": return 6'd40; "/": return 6'd42; "%": return 6'd44; "=": return 6'd45;
			"<": return 6'd49; ">": return 6'd52; "#": return 6'd53;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] pairs(input logic [7:0] a, input logic [7:0] c);
		case ({a, c})
			"&&": return 6'd26; "&=": return 6'd27; "||": return 6'd29; "|=": return 6'd30;
			"++": return 6'd32; "+=": return 6'd33; "--": return 6'd35; "->": return 6'd36;
			"-=": return 6'd37; "*=": return 6'd39; "/=": return 6'd41; "%=": return 6'd43;
			"==": return 6'd46; "<=": return 6'd47; "<<": return 6'd48; ">=": return 6'd50;
			">>": return 6'd51; "##": return 6'd54;
			default: return K_NONE;
		endcase
	endfunction

	function automatic void add_token(input logic [5:0] k, input logic [OB-1:0] s,
		input logic [LB-1:0] l);
		token_t t;
		t.kind = k; t.start = s; t.len = l; t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void extend();
		if (run_len != '1)
			run_len++;
	endfunction

	// close whatever token is open, as if a non-matching byte followed
	function automatic void flush_open();
		logic [5:0] k;
		k = K_COMMENT;
		case (mode)
			M_IDLE: return;
			M_OP: k = leads(lead_byte);
			M_BSL: k = K_BSL;
			M_DOTS: begin
				add_token(K_DOT, run_start, LB'(1));
				if (dots == 2'd2)
					add_token(K_DOT, run_start + 1'b1, LB'(1));
				dots = 2'd0;
				mode = M_IDLE;
				return;
			end
			M_CR: k = K_NEWLINE;
			M_SPACE: k = K_SPACE;
			M_IDENT: k = K_IDENT;
			M_NUM, M_NUMT: k = K_INT;
			M_NUMF: k = K_FLOAT;
			M_QUOTE: k = K_INVALID;
			default: k = K_COMMENT;
		endcase
		add_token(k, run_start, run_len);
		mode = M_IDLE;
		esc = 1'b0;
	endfunction

	// offer a byte to the open token; returns 1 when absorbed
	function automatic bit absorb(input logic [7:0] c);
		logic [5:0] k;
		case (mode)
			M_IDLE: return 0;
			M_OP: begin
				if (lead_byte == C_SLASH && c == C_SLASH) begin
					extend(); mode = M_LINEC; return 1;
				end
				if (lead_byte == C_SLASH && c == C_STAR) begin
					extend(); mode = M_BLOCK; return 1;
				end
				k = pairs(lead_byte, c);
				if (k != K_NONE) begin
					extend(); add_token(k, run_start, run_len); mode = M_IDLE; return 1;
				end
			end
			M_BSL, M_CR: if (c == C_LF) begin
				extend();
				add_token(mode == M_BSL ? K_SPACE : K_NEWLINE, run_start, run_len);
				mode = M_IDLE;
				return 1;
			end
			M_DOTS: if (c == C_DOT) begin
				if (dots < 2'd2) begin
					dots = 2'd2; extend(); return 1;
				end
				add_token(K_ELLIP, run_start, LB'(3));
				dots = 2'd0; mode = M_IDLE;
				return 1;
			end
			M_SPACE: if (is_ws(c)) begin
				extend(); return 1;
			end
			M_IDENT, M_NUMF, M_NUMT: if (is_wordc(c)) begin
				extend(); return 1;
			end
			M_NUM: begin
				if (is_dec_digit(c)) begin
					extend(); return 1;
				end
				if (c == C_DOT) begin
					extend(); mode = M_NUMF; return 1;
				end
				if (is_wordc(c)) begin
					extend(); mode = M_NUMT; return 1;
				end
			end
			M_QUOTE: begin
				if (esc) begin
					esc = 1'b0; extend(); return 1;
				end
				if (c == quote) begin
					extend();
					add_token(quote == C_DQUOTE ? K_STRING : K_CHAR, run_start, run_len);
					mode = M_IDLE;
					return 1;
				end
				if (c != C_LF) begin
					if (c == C_BSLASH)
						esc = 1'b1;
					extend();
					return 1;
				end
			end
			M_LINEC: if (c != C_LF) begin
				extend(); return 1;
			end
			M_BLOCK: begin
				extend();
				if (c == C_STAR)
					mode = M_BSTAR;
				return 1;
			end
			default: begin
				extend();
				if (c == C_SLASH) begin
					add_token(K_COMMENT, run_start, run_len); mode = M_IDLE;
				end else if (c != C_STAR)
					mode = M_BLOCK;
				return 1;
			end
		endcase
		flush_open();
		return 0;
	endfunction

	task automatic open_token(input logic [7:0] c, input logic [OB-1:0] pos);
		logic [5:0] k;
		k = singles(c);
		run_start = pos;
		run_len = LB'(1);
		esc = 1'b0;
		if (k != K_NONE) begin
			add_token(k, pos, LB'(1)); return;
		end
		if (leads(c) != K_NONE) begin
			lead_byte = c; mode = M_OP; return;
		end
		case (c)
			C_LF: add_token(K_NEWLINE, pos, LB'(1));
			C_CR: mode = M_CR;
			C_BSLASH: mode = M_BSL;
			C_DOT: begin
				dots = 2'd1; mode = M_DOTS;
			end
			" ", 8'h09, 8'h0B, 8'h0C: mode = M_SPACE;
			C_SQUOTE, C_DQUOTE: begin
				quote = c; mode = M_QUOTE;
			end
			default: begin
				if (is_dec_digit(c))
					mode = M_NUM;
				else if (is_wordc(c))
					mode = M_IDENT;
				else
					add_token(K_INVALID, pos, LB'(1));
			end
		endcase
	endtask

	// work out the tokens caused by one request
	task automatic tokenize(input logic [7:0] c, input logic fin);
		logic [OB-1:0] pos;
		step_tokens.delete();
		if (fin || c == 8'h00) begin
			flush_open();
			add_token(K_EOF, offset, '0);
		end else begin
			pos = offset;
			offset++;
			if (!absorb(c))
				open_token(c, pos);
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size()-1].last = 1'b1;
	endtask

	// directed table
	row_t rows [$];

	task automatic add_row(input logic [7:0] c, input logic fin);
		row_t r;
		r.b = c; r.fin = fin; r.n_fixed = 0;
		rows.push_back(r);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_row(s[i], 1'b0);
	endtask

	function automatic token_t tok(input logic [5:0] k, input int s, input int l, input bit z);
		token_t t;
		t.kind = k; t.start = s; t.len = LB'(l); t.last = z;
		return t;
	endfunction

	task automatic send(input logic [7:0] c, input logic fin);
		int gap;
		tokenize(c, fin);
		foreach (step_tokens[i])
			pending_tokens.push_back(step_tokens[i]);
		source_byte <= c;
		end_of_input <= fin;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 15) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 3));
		if (gap > 0) begin
			in_valid <= 1'b0;
			source_byte <= 8'($urandom);
			end_of_input <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// random byte biased toward well-formed C text
	function automatic logic [7:0] random_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return pick("abcxyzABZ_019");
		if (r < 35) return pick(" \t\n\r");
		if (r < 55) return pick("&|+-*/%=<>#.");
		if (r < 65) return pick("()[]{}?,:;~^!");
		if (r < 75) return pick("\"'\\");
		if (r < 85) return pick("0123456789.eE");
		if (r < 88) return 8'h00;
		return 8'($urandom);
	endfunction

	// stimulus
	initial begin
		mode = M_IDLE; lead_byte = '0; dots = 2'd0; quote = '0; esc = 1'b0;
		run_len = '0; run_start = '0; offset = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end mark right after reset, then extremes and special cases
		add_row(8'h00, 1'b0);
		rows[0].n_fixed = 1; rows[0].fixed[0] = tok(K_EOF, 0, 0, 1);
		add_row(8'hFF, 1'b0);
		rows[1].n_fixed = 1; rows[1].fixed[0] = tok(K_INVALID, 0, 1, 1);
		add_row(8'h41, 1'b1);
		rows[2].n_fixed = 1; rows[2].fixed[0] = tok(K_EOF, 1, 0, 1);
		add_text("..+/*/*/'\\n\n\"a");
		add_row(8'h00, 1'b1);
		add_text("1.5e.\r\n\\\n..;");
		// walk the table; typed-in rows still advance the predictor
		foreach (rows[i]) begin
			if (rows[i].n_fixed > 0) begin
				tokenize(rows[i].b, rows[i].fin);
				for (int j = 0; j < rows[i].n_fixed; j++)
					pending_tokens.push_back(rows[i].fixed[j]);
				source_byte <= rows[i].b;
				end_of_input <= rows[i].fin;
				in_valid <= 1'b1;
				do
					@(posedge clk);
				while (in_stall);
			end else
				send(rows[i].b, rows[i].fin);
		end

		// random part, with a long receiver hold-off partway
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				long_hold = 1;
			if ($urandom_range(0, 200) == 0)
				send(8'h00, 1'b1);
			else
				send(random_byte(), $urandom_range(0, 60) == 0);
		end
		in_valid <= 1'b0;
		sending_done = 1;
	end

	// receiver stalls
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 0;
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
			end
			hold = ($urandom_range(0, 9) < 6) ? 0 :
				($urandom_range(0, 15) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 3));
			if (hold == 0)
				out_stall <= 1'b0;
			else begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// token checker
	always @(posedge clk) begin
		token_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {token_class, token_start, token_length, last_result};
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token kind %0d start %0d len %0d",
						token_class, token_start, token_length);
			end else begin
				want = pending_tokens.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("token mismatch: exp k%0d s%0d l%0d e%0b got k%0d s%0d l%0d e%0b",
							want.kind, want.start, want.len, want.last,
							got.kind, got.start, got.len, got.last);
				end
			end
		end
	end

	// end of run
	initial begin
		wait (sending_done && pending_tokens.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/cst_pkg.sv
hdl/cst_front.sv
hdl/cst_back.sv
hdl/c_source_tokenizer.sv
verif/tb_c_source_tokenizer.sv
